### hw/rtl/simple_glyph_outline_decoder_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the simple glyph outline decoder.
// Both macros sample on clk and are disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef SIMPLE_GLYPH_OUTLINE_DECODER_MACROS_SVH
`define SIMPLE_GLYPH_OUTLINE_DECODER_MACROS_SVH

// Check that a condition implies another in the same cycle
`define SGOD_ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that a condition never holds
`define SGOD_ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

### hw/rtl/sgod_pkg.sv
// ---------------------------------------------------------------------------
// sgod_pkg
// Result kinds, status codes and flag bit positions of the glyph decoder.
// ---------------------------------------------------------------------------
package sgod_pkg;

    typedef logic [1:0] kind_t;
    typedef logic [2:0] status_t;

    localparam kind_t KIND_HEADER  = 2'd0;
    localparam kind_t KIND_CONTOUR = 2'd1;
    localparam kind_t KIND_POINT   = 2'd2;

    localparam status_t ST_OK        = 3'd0;
    localparam status_t ST_EMPTY     = 3'd1;
    localparam status_t ST_COMPOSITE = 3'd2;
    localparam status_t ST_RESERVED  = 3'd3;
    localparam status_t ST_OVERRUN   = 3'd4;
    localparam status_t ST_TOO_MANY  = 3'd5;

    // Point flag bits
    localparam int FB_ON       = 0;
    localparam int FB_XSHORT   = 1;
    localparam int FB_YSHORT   = 2;
    localparam int FB_REPEAT   = 3;
    localparam int FB_XSAME    = 4;
    localparam int FB_YSAME    = 5;
    localparam int FB_RESERVED = 7;

    localparam logic [2:0] LAST_HEADER_WORD = 3'd4;

endpackage

### hw/rtl/sgod_in_if.sv
// ---------------------------------------------------------------------------
// sgod_in_if
// Byte stream channel into the glyph decoder.
// ---------------------------------------------------------------------------
interface sgod_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       first_byte;

    modport source (output valid, output data_byte, output first_byte, input ready);
    modport sink   (input valid, input data_byte, input first_byte, output ready);
endinterface

### hw/rtl/sgod_out_if.sv
// ---------------------------------------------------------------------------
// sgod_out_if
// Result channel out of the glyph decoder.
// ---------------------------------------------------------------------------
interface sgod_out_if;
    logic               valid;
    logic               ready;
    logic [1:0]         kind;
    logic [15:0]        index;
    logic signed [16:0] value_a;
    logic signed [15:0] value_b;
    logic               on_curve;
    logic [2:0]         status;
    logic               last;

    modport source (output valid, output kind, output index, output value_a,
                    output value_b, output on_curve, output status, output last,
                    input ready);
    modport sink   (input valid, input kind, input index, input value_a,
                    input value_b, input on_curve, input status, input last,
                    output ready);
endinterface

### hw/rtl/simple_glyph_outline_decoder.sv
// ---------------------------------------------------------------------------
// simple_glyph_outline_decoder
// Decodes a simple glyph record byte by byte into header words, contour
// end points and points with x, y and on-curve bit.
// ---------------------------------------------------------------------------
// Input: a byte is taken whenever the output register is free and the
// sequencer is in a state that waits for input. A repeat count of n holds
// input while the flag memory is filled with n more copies of the flag,
// one entry a cycle. Every point of the x and y passes goes through a
// registered flag/x memory read and its evaluation; a point that takes a
// delta then waits for its byte, or for two bytes for a word delta.
// Points that need no delta byte are decoded from the memories without
// taking input, and a y point also waits while the output register is
// held. Up to MAX_POINTS points are held; more gives status 5 on the
// final contour result.
module simple_glyph_outline_decoder #(
    parameter int MAX_POINTS = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    sgod_in_if.sink     in_ch,
    sgod_out_if.source  out_ch
);
    import sgod_pkg::*;

    localparam int PW = $clog2(MAX_POINTS + 1);
    localparam int AW = $clog2(MAX_POINTS);

    typedef enum logic [3:0] {
        S_IDLE, S_HEADER, S_ENDPTS, S_ILEN, S_SKIP, S_FLAGS, S_REPEAT, S_RFILL,
        S_XRD, S_XEVAL, S_XW, S_YRD, S_YEVAL, S_YW
    } state_t;

    state_t      state_reg;
    logic [7:0]  hold_reg;
    logic        tog_reg;
    logic [2:0]  hc_reg;
    logic [15:0] ct_reg;
    logic [14:0] cc_reg;
    logic [PW-1:0] pt_reg;
    logic [PW-1:0] pc_reg;
    logic [15:0] skip_reg;
    logic [5:0]  rep_hold_reg;
    logic [7:0]  rep_left_reg;
    logic [15:0] rc_reg;

    // Output register
    logic               ov_reg;
    kind_t              o_kind_reg;
    logic [15:0]        o_index_reg;
    logic signed [16:0] o_a_reg;
    logic signed [15:0] o_b_reg;
    logic               o_on_reg;
    status_t            o_status_reg;
    logic               o_last_reg;

    // Memories
    logic [5:0]  flag_mem [MAX_POINTS];
    logic [15:0] x_mem [MAX_POINTS];
    logic [5:0]  flag_q;
    logic [15:0] x_q;
    logic [AW-1:0] addr;

    logic        slot_free, waiting, in_fire, byte_go, first;
    logic [7:0]  din;
    logic [15:0] word;
    logic        short_d, pos_d, delta_done;
    logic [15:0] coord_new;
    logic        pt_last;
    logic        x_byteless, y_byteless;
    logic        flag_we, x_we;
    logic [5:0]  flag_wdata;
    logic [15:0] x_wdata;

    logic        em_valid, em_last;
    kind_t       em_kind;
    logic [15:0] em_index;
    logic [16:0] em_a;
    logic [15:0] em_b;
    logic        em_on;
    status_t     em_status;

    // Handshake
    assign slot_free = !ov_reg || out_ch.ready;
    assign waiting = (state_reg == S_IDLE) || (state_reg == S_HEADER)
                  || (state_reg == S_ENDPTS) || (state_reg == S_ILEN)
                  || (state_reg == S_SKIP) || (state_reg == S_FLAGS)
                  || (state_reg == S_REPEAT) || (state_reg == S_XW)
                  || (state_reg == S_YW);
    assign in_ch.ready = waiting && slot_free;
    assign in_fire = in_ch.valid && in_ch.ready;
    assign first = in_ch.first_byte;
    assign din = in_ch.data_byte;
    assign byte_go = in_fire && !first;
    assign word = {hold_reg, din};
    assign addr = pc_reg[AW-1:0];

    // Delta arithmetic for the x and y passes
    always_comb
    begin
        if (state_reg == S_XW)
        begin
            short_d = flag_q[FB_XSHORT];
            pos_d   = flag_q[FB_XSAME];
        end
        else
        begin
            short_d = flag_q[FB_YSHORT];
            pos_d   = flag_q[FB_YSAME];
        end
        if (short_d)
            coord_new = pos_d ? rc_reg + {8'd0, din} : rc_reg - {8'd0, din};
        else
            coord_new = rc_reg + word;
        delta_done = short_d || tog_reg;
    end

    assign x_byteless = flag_q[FB_XSAME] && !flag_q[FB_XSHORT];
    assign y_byteless = flag_q[FB_YSAME] && !flag_q[FB_YSHORT];
    assign pt_last = ((PW+1)'(pc_reg) + (PW+1)'(1)) == (PW+1)'(pt_reg);

    // Result selection
    always_comb
    begin
        em_valid  = 1'b0;
        em_kind   = KIND_HEADER;
        em_index  = 16'd0;
        em_a      = 17'd0;
        em_b      = 16'd0;
        em_on     = 1'b0;
        em_status = ST_OK;
        em_last   = 1'b0;
        unique case (state_reg)
            S_HEADER:
                if (byte_go && tog_reg)
                begin
                    em_valid = 1'b1;
                    em_index = {13'd0, hc_reg};
                    em_a     = {word[15], word};
                    if (hc_reg == LAST_HEADER_WORD)
                    begin
                        if (ct_reg == 16'd0)
                        begin
                            em_status = ST_EMPTY;
                            em_last   = 1'b1;
                        end
                        else if (ct_reg[15])
                        begin
                            em_status = ST_COMPOSITE;
                            em_last   = 1'b1;
                        end
                    end
                end
            S_ENDPTS:
                if (byte_go && tog_reg)
                begin
                    em_valid = 1'b1;
                    em_kind  = KIND_CONTOUR;
                    em_index = {1'b0, cc_reg};
                    em_a     = {1'b0, word};
                    if ({1'b0, cc_reg} + 16'd1 >= ct_reg
                        && {1'b0, word} + 17'd1 > 17'(MAX_POINTS))
                    begin
                        em_status = ST_TOO_MANY;
                        em_last   = 1'b1;
                    end
                end
            S_FLAGS:
                if (byte_go && din[FB_RESERVED])
                begin
                    em_valid  = 1'b1;
                    em_kind   = KIND_POINT;
                    em_index  = 16'(pc_reg);
                    em_status = ST_RESERVED;
                    em_last   = 1'b1;
                end
            S_REPEAT:
                if (byte_go && (17'(pc_reg) + 17'(din) > 17'(pt_reg)))
                begin
                    em_valid  = 1'b1;
                    em_kind   = KIND_POINT;
                    em_index  = 16'(pc_reg);
                    em_status = ST_OVERRUN;
                    em_last   = 1'b1;
                end
            S_YEVAL:
                if (y_byteless && slot_free)
                begin
                    em_valid = 1'b1;
                    em_kind  = KIND_POINT;
                    em_index = 16'(pc_reg);
                    em_a     = {x_q[15], x_q};
                    em_b     = rc_reg;
                    em_on    = flag_q[FB_ON];
                    em_last  = pt_last;
                end
            S_YW:
                if (byte_go && delta_done)
                begin
                    em_valid = 1'b1;
                    em_kind  = KIND_POINT;
                    em_index = 16'(pc_reg);
                    em_a     = {x_q[15], x_q};
                    em_b     = coord_new;
                    em_on    = flag_q[FB_ON];
                    em_last  = pt_last;
                end
            default: ;
        endcase
    end

    // Memory write controls
    always_comb
    begin
        flag_we    = 1'b0;
        flag_wdata = rep_hold_reg;
        x_we       = 1'b0;
        x_wdata    = coord_new;
        case (state_reg)
            S_FLAGS:
            begin
                flag_we    = byte_go && !din[FB_RESERVED];
                flag_wdata = din[5:0];
            end
            S_RFILL:
                flag_we = (rep_left_reg != 8'd0);
            S_XEVAL:
            begin
                x_we    = (pc_reg < pt_reg) && x_byteless;
                x_wdata = rc_reg;
            end
            S_XW:
                x_we = byte_go && delta_done;
            default: ;
        endcase
    end

    // Flag and x memories, registered read at the current point
    always_ff @(posedge clk)
    begin
        if (flag_we)
            flag_mem[addr] <= flag_wdata;
        if (x_we)
            x_mem[addr] <= x_wdata;
        flag_q <= flag_mem[addr];
        x_q    <= x_mem[addr];
    end

    // Sequencer and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            hold_reg     <= 8'd0;
            tog_reg      <= 1'b0;
            hc_reg       <= 3'd0;
            ct_reg       <= 16'd0;
            cc_reg       <= 15'd0;
            pt_reg       <= '0;
            pc_reg       <= '0;
            skip_reg     <= 16'd0;
            rep_hold_reg <= 6'd0;
            rep_left_reg <= 8'd0;
            rc_reg       <= 16'd0;
            ov_reg       <= 1'b0;
        end
        else
        begin
            // Drain the output register, load a new transaction
            if (out_ch.ready)
                ov_reg <= 1'b0;
            if (em_valid)
            begin
                ov_reg       <= 1'b1;
                o_kind_reg   <= em_kind;
                o_index_reg  <= em_index;
                o_a_reg      <= em_a;
                o_b_reg      <= em_b;
                o_on_reg     <= em_on;
                o_status_reg <= em_status;
                o_last_reg   <= em_last;
            end

            if (in_fire && first)
            begin
                // Start a new record with this byte as the first high byte
                state_reg <= S_HEADER;
                hold_reg  <= din;
                tog_reg   <= 1'b1;
                hc_reg    <= 3'd0;
                cc_reg    <= 15'd0;
                pc_reg    <= '0;
                rc_reg    <= 16'd0;
            end
            else
            begin
                unique case (state_reg)
                    S_IDLE: ;
                    S_HEADER:
                        if (byte_go)
                        begin
                            hold_reg <= din;
                            tog_reg  <= !tog_reg;
                            if (tog_reg)
                            begin
                                if (hc_reg == 3'd0)
                                    ct_reg <= word;
                                if (hc_reg == LAST_HEADER_WORD)
                                begin
                                    cc_reg    <= 15'd0;
                                    state_reg <= em_last ? S_IDLE : S_ENDPTS;
                                end
                                else
                                    hc_reg <= hc_reg + 3'd1;
                            end
                        end
                    S_ENDPTS:
                        if (byte_go)
                        begin
                            hold_reg <= din;
                            tog_reg  <= !tog_reg;
                            if (tog_reg)
                            begin
                                cc_reg <= cc_reg + 15'd1;
                                if ({1'b0, cc_reg} + 16'd1 >= ct_reg)
                                begin
                                    pt_reg    <= PW'({1'b0, word} + 17'd1);
                                    state_reg <= em_last ? S_IDLE : S_ILEN;
                                end
                            end
                        end
                    S_ILEN:
                        if (byte_go)
                        begin
                            hold_reg <= din;
                            tog_reg  <= !tog_reg;
                            if (tog_reg)
                            begin
                                skip_reg  <= word;
                                pc_reg    <= '0;
                                state_reg <= (word != 16'd0) ? S_SKIP : S_FLAGS;
                            end
                        end
                    S_SKIP:
                        if (byte_go)
                        begin
                            skip_reg <= skip_reg - 16'd1;
                            if (skip_reg == 16'd1)
                                state_reg <= S_FLAGS;
                        end
                    S_FLAGS:
                        if (byte_go)
                        begin
                            if (din[FB_RESERVED])
                                state_reg <= S_IDLE;
                            else
                            begin
                                pc_reg <= pc_reg + PW'(1);
                                if (din[FB_REPEAT])
                                begin
                                    rep_hold_reg <= din[5:0];
                                    state_reg    <= S_REPEAT;
                                end
                                else if ((PW+1)'(pc_reg) + (PW+1)'(1)
                                         >= (PW+1)'(pt_reg))
                                begin
                                    pc_reg    <= '0;
                                    rc_reg    <= 16'd0;
                                    tog_reg   <= 1'b0;
                                    state_reg <= S_XRD;
                                end
                            end
                        end
                    S_REPEAT:
                        if (byte_go)
                        begin
                            if (em_valid)
                                state_reg <= S_IDLE;
                            else
                            begin
                                rep_left_reg <= din;
                                state_reg    <= S_RFILL;
                            end
                        end
                    S_RFILL:
                        if (rep_left_reg != 8'd0)
                        begin
                            rep_left_reg <= rep_left_reg - 8'd1;
                            pc_reg       <= pc_reg + PW'(1);
                        end
                        else if (pc_reg >= pt_reg)
                        begin
                            pc_reg    <= '0;
                            rc_reg    <= 16'd0;
                            tog_reg   <= 1'b0;
                            state_reg <= S_XRD;
                        end
                        else
                            state_reg <= S_FLAGS;
                    S_XRD:
                        state_reg <= S_XEVAL;
                    S_XEVAL:
                        if (pc_reg >= pt_reg)
                        begin
                            pc_reg    <= '0;
                            rc_reg    <= 16'd0;
                            tog_reg   <= 1'b0;
                            state_reg <= S_YRD;
                        end
                        else if (x_byteless)
                        begin
                            pc_reg    <= pc_reg + PW'(1);
                            state_reg <= S_XRD;
                        end
                        else
                            state_reg <= S_XW;
                    S_XW:
                        if (byte_go)
                        begin
                            hold_reg <= din;
                            if (!short_d)
                                tog_reg <= !tog_reg;
                            if (delta_done)
                            begin
                                rc_reg    <= coord_new;
                                pc_reg    <= pc_reg + PW'(1);
                                state_reg <= S_XRD;
                            end
                        end
                    S_YRD:
                        state_reg <= S_YEVAL;
                    S_YEVAL:
                        if (!y_byteless)
                            state_reg <= S_YW;
                        else if (slot_free)
                        begin
                            pc_reg    <= pc_reg + PW'(1);
                            state_reg <= pt_last ? S_IDLE : S_YRD;
                        end
                    S_YW:
                        if (byte_go)
                        begin
                            hold_reg <= din;
                            if (!short_d)
                                tog_reg <= !tog_reg;
                            if (delta_done)
                            begin
                                rc_reg    <= coord_new;
                                pc_reg    <= pc_reg + PW'(1);
                                state_reg <= pt_last ? S_IDLE : S_YRD;
                            end
                        end
                    default:
                        state_reg <= S_IDLE;
                endcase
            end
        end
    end

    assign out_ch.valid    = ov_reg;
    assign out_ch.kind     = o_kind_reg;
    assign out_ch.index    = o_index_reg;
    assign out_ch.value_a  = o_a_reg;
    assign out_ch.value_b  = o_b_reg;
    assign out_ch.on_curve = o_on_reg;
    assign out_ch.status   = o_status_reg;
    assign out_ch.last     = o_last_reg;

`include "simple_glyph_outline_decoder_macros.svh"

    `SGOD_ASSERT_IMPLIES(a_ready_slot, in_ch.ready, slot_free, "byte taken with output blocked")
    `SGOD_ASSERT_NEVER(a_pc_range, pc_reg > PW'(MAX_POINTS), "point counter beyond capacity")
    `SGOD_ASSERT_IMPLIES(a_emit_free, em_valid, slot_free, "result produced with output blocked")

endmodule
